// ----- rtl/rrnpd_pkg.sv -----
`timescale 1ns / 1ps

package rrnpd_pkg;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [15:0] WIDTH_RESET  = 16'd1;
  localparam logic [15:0] HEIGHT_RESET = 16'd1;

  localparam logic [7:0] CHAN_MASK = 8'hf0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [15:0] run_length;
    logic [7:0]  cyan;
    logic [7:0]  magenta;
    logic [7:0]  yellow;
    logic        row_end;
    logic        image_end;
    logic        last;
  } run_t;

  // runs caused by one byte: count, then first and second
  typedef struct packed {
    logic [1:0] n;
    run_t       r0;
    run_t       r1;
  } emit_t;

endpackage

// ----- rtl/rrnpd_ifs.sv -----
`timescale 1ns / 1ps

interface rrnpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rrnpd_run_if;
  logic        valid;
  logic        ready;
  logic [15:0] run_length;
  logic [7:0]  cyan;
  logic [7:0]  magenta;
  logic [7:0]  yellow;
  logic        row_end;
  logic        image_end;
  logic        last;

  modport source (
    output valid, output run_length, output cyan, output magenta, output yellow,
    output row_end, output image_end, output last, input ready
  );
  modport sink (
    input valid, input run_length, input cyan, input magenta, input yellow,
    input row_end, input image_end, input last, output ready
  );
endinterface

interface rrnpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rrnpd_core.sv -----
`timescale 1ns / 1ps

module rrnpd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        byte_in,
  input  logic [15:0]       width,
  input  logic [15:0]       height,
  output rrnpd_pkg::emit_t  emit
);
  import rrnpd_pkg::*;

  typedef enum logic [1:0] {PH_WHITE, PH_COUNT, PH_DATA} row_phase_t;
  typedef enum logic [1:0] {NB_EDGE, NB_ONE, NB_TWO} nibble_t;

  row_phase_t  phase, phase_next;
  nibble_t     nibble, nibble_next;
  logic [15:0] row_index, row_index_next;
  logic [16:0] column, column_next;
  logic [7:0]  pixels_left, pixels_left_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        image_done, image_done_next;

  logic [16:0] width_x;
  logic [16:0] rem;
  logic [16:0] col1;
  logic [16:0] rem2;
  logic [15:0] row_inc;
  logic        last_row;
  logic        close;
  logic        done;
  logic        shown;
  logic [7:0]  pl_dec;
  logic [7:0]  c, m, y;
  run_t        fill0, fill2;

  assign width_x  = {1'b0, width};
  assign rem      = (column < width_x) ? (width_x - column) : 17'd0;
  assign col1     = column + 17'd1;
  assign rem2     = (col1 < width_x) ? (width_x - col1) : 17'd0;
  assign row_inc  = row_index + 16'd1;
  assign last_row = (row_inc >= height);
  assign pl_dec   = pixels_left - 8'd1;

  always_comb begin
    fill0 = '{run_length: rem[15:0], cyan: 8'h00, magenta: 8'h00, yellow: 8'h00,
              row_end: 1'b1, image_end: last_row, last: 1'b1};
    fill2 = '{run_length: rem2[15:0], cyan: 8'h00, magenta: 8'h00, yellow: 8'h00,
              row_end: 1'b1, image_end: last_row, last: 1'b1};
  end

  always_comb begin
    phase_next       = phase;
    nibble_next      = nibble;
    row_index_next   = row_index;
    column_next      = column;
    pixels_left_next = pixels_left;
    held_byte_next   = held_byte;
    image_done_next  = image_done;
    emit             = '0;
    close            = 1'b0;
    done             = 1'b0;
    shown            = 1'b0;
    c                = 8'h00;
    m                = 8'h00;
    y                = 8'h00;

    if (!image_done) begin
      if (phase != PH_DATA && {8'h00, byte_in} == width) begin
        emit.n  = 2'd1;
        emit.r0 = fill0;
        close   = 1'b1;
      end else begin
        unique case (phase)
          PH_WHITE: begin
            if ({9'h000, byte_in} >= rem) begin
              emit.n  = 2'd1;
              emit.r0 = fill0;
              close   = 1'b1;
            end else begin
              if (byte_in != 8'h00) begin
                emit.n               = 2'd1;
                emit.r0.run_length   = {8'h00, byte_in};
                emit.r0.last         = 1'b1;
              end
              column_next = column + {9'h000, byte_in};
              phase_next  = PH_COUNT;
            end
          end
          PH_COUNT: begin
            pixels_left_next = byte_in;
            nibble_next      = NB_EDGE;
            if (byte_in == 8'h00) begin
              emit.n  = 2'd1;
              emit.r0 = fill0;
              close   = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            unique case (nibble)
              NB_ONE: begin
                c              = held_byte & CHAN_MASK;
                m              = {held_byte[3:0], 4'h0};
                y              = byte_in & CHAN_MASK;
                held_byte_next = byte_in;
                nibble_next    = NB_TWO;
                done           = 1'b1;
              end
              NB_TWO: begin
                c           = {held_byte[3:0], 4'h0};
                m           = byte_in & CHAN_MASK;
                y           = {byte_in[3:0], 4'h0};
                nibble_next = NB_EDGE;
                done        = 1'b1;
              end
              default: begin
                held_byte_next = byte_in;
                nibble_next    = NB_ONE;
              end
            endcase
            if (done) begin
              pixels_left_next = pl_dec;
              shown            = (column < width_x);
              if (shown) begin
                emit.n  = 2'd1;
                emit.r0 = '{run_length: 16'd1, cyan: c, magenta: m, yellow: y,
                            row_end: 1'b0, image_end: 1'b0, last: 1'b1};
                column_next = col1;
              end
              if (pl_dec == 8'h00) begin
                close = 1'b1;
                if (shown && col1 >= width_x) begin
                  emit.r0.row_end   = 1'b1;
                  emit.r0.image_end = last_row;
                end else if (shown) begin
                  emit.r0.last = 1'b0;
                  emit.r1      = fill2;
                  emit.n       = 2'd2;
                end else begin
                  emit.r0 = fill2;
                  emit.n  = 2'd1;
                end
              end
            end
          end
          default: begin
            phase_next = PH_WHITE;
          end
        endcase
      end

      if (close) begin
        row_index_next   = row_inc;
        column_next      = 17'd0;
        phase_next       = PH_WHITE;
        pixels_left_next = 8'h00;
        nibble_next      = NB_EDGE;
        if (last_row) begin
          image_done_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WHITE;
      nibble      <= NB_EDGE;
      row_index   <= 16'd0;
      column      <= 17'd0;
      pixels_left <= 8'h00;
      held_byte   <= 8'h00;
      image_done  <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      nibble      <= nibble_next;
      row_index   <= row_index_next;
      column      <= column_next;
      pixels_left <= pixels_left_next;
      held_byte   <= held_byte_next;
      image_done  <= image_done_next;
    end
  end

endmodule

// ----- rtl/rrnpd_queue.sv -----
`timescale 1ns / 1ps

module rrnpd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rrnpd_pkg::emit_t emit,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output rrnpd_pkg::run_t  head
);
  import rrnpd_pkg::*;

  run_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic [QUEUE_CNT_W-1:0] n_push;
  logic                   pop;

  assign room      = (count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
  assign out_valid = (count != '0);
  assign head      = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign n_push    = push ? QUEUE_CNT_W'(emit.n) : '0;

  always_ff @(posedge clk) begin
    if (push && emit.n != 2'd0) begin
      entries[wr_ptr] <= emit.r0;
    end
    if (push && emit.n == 2'd2) begin
      entries[wr_ptr + QUEUE_PTR_W'(1)] <= emit.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      count <= count + n_push - QUEUE_CNT_W'(pop);
    end
  end

endmodule

// ----- rtl/row_run_nibble_pixel_decoder.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Contents
// cfg      in   index (0 image_width, 1 image_height), data
// pixels   in   data_byte
// runs     out  run_length, cyan, magenta, yellow, row_end, image_end, last
//
// Takes one byte a cycle while the run queue has room; a taken byte is registered, then its runs enter the queue.
// Most bytes give at most one run; the four-entry run queue takes a byte while no
// more than two runs wait, so the sustained rate follows runs taken.
// Synchronous reset clears decoder state, queue and registers (both to 1).
// A stall on runs stops byte intake once the queue cannot take two more runs.

module row_run_nibble_pixel_decoder (
  input  logic               clk,
  input  logic               rst,
  rrnpd_cfg_if.sink          cfg,
  rrnpd_byte_if.sink         pixels,
  rrnpd_run_if.source        runs
);
  import rrnpd_pkg::*;

  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        s_valid;
  logic [7:0]  s_byte;
  logic        room;
  logic        fire;
  emit_t       emit;
  run_t        head;
  logic        q_valid;

  assign cfg.ready    = 1'b1;
  assign fire         = s_valid && room;
  assign pixels.ready = !s_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (pixels.ready) begin
      s_valid <= pixels.valid;
    end
    if (pixels.valid && pixels.ready) begin
      s_byte <= pixels.data_byte;
    end
  end

  rrnpd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (s_byte),
    .width   (image_width),
    .height  (image_height),
    .emit    (emit)
  );

  rrnpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .emit      (emit),
    .room      (room),
    .out_valid (q_valid),
    .out_ready (runs.ready),
    .head      (head)
  );

  assign runs.valid      = q_valid;
  assign runs.run_length = head.run_length;
  assign runs.cyan       = head.cyan;
  assign runs.magenta    = head.magenta;
  assign runs.yellow     = head.yellow;
  assign runs.row_end    = head.row_end;
  assign runs.image_end  = head.image_end;
  assign runs.last       = head.last;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rrnpd_pkg::*;

  typedef enum logic [1:0] {EXPECT_WHITE, EXPECT_COUNT, IN_DATA} row_phase_e;

  localparam logic [1:0] NIB_ALIGNED = 2'd0;
  localparam logic [1:0] NIB_HELD    = 2'd1;
  localparam logic [1:0] NIB_SPLIT   = 2'd2;

  typedef struct {
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] row_idx;
    logic [16:0] col;
    row_phase_e  phase;
    logic [7:0]  left;
    logic [1:0]  nib;
    logic [7:0]  held;
    logic        done;
  } decoder_state_t;

  logic clk = 1'b0;
  logic rst;

  rrnpd_cfg_if  cfg_ch ();
  rrnpd_byte_if byte_ch ();
  rrnpd_run_if  run_ch ();

  row_run_nibble_pixel_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .pixels (byte_ch),
    .runs   (run_ch)
  );

  always #1 clk = ~clk;

  logic [7:0]     pending_bytes [$];
  run_t           expected_runs [$];
  decoder_state_t dec_st;
  decoder_state_t gen_st;
  int             items_queued = 0;
  int             mismatches = 0;
  logic           byte_taken = 1'b0;
  int             burst_left = 0;
  int             gap_left = 0;
  int             hold_left = 0;
  int             holds_asked = 0;
  int             holds_granted = 0;
  int             stall_mode = 0;
  int             mode_left = 0;

  // zero white, whole row, whole-row byte mid-row, zero count, clipped white,
  // colour run hitting the row end, pixels past the row end with odd count
  logic [7:0] opening_bytes [0:24] = '{
    8'h00, 8'h02, 8'hab, 8'hcd, 8'hef,
    8'h06,
    8'h03, 8'h06,
    8'h04, 8'h00,
    8'h09,
    8'h04, 8'h02, 8'hff, 8'h00, 8'hff,
    8'h05, 8'h03, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9a,
    8'hff,
    8'h00
  };

  function automatic decoder_state_t reset_state();
    decoder_state_t s;
    s.width   = WIDTH_RESET;
    s.height  = HEIGHT_RESET;
    s.row_idx = '0;
    s.col     = '0;
    s.phase   = EXPECT_WHITE;
    s.left    = '0;
    s.nib     = NIB_ALIGNED;
    s.held    = '0;
    s.done    = 1'b0;
    return s;
  endfunction

  function automatic logic [16:0] rest_of_row(decoder_state_t s);
    return (s.col < {1'b0, s.width}) ? {1'b0, s.width} - s.col : 17'd0;
  endfunction

  function automatic run_t make_run(logic [16:0] len, logic re, logic ie);
    run_t r;
    r = '0;
    r.run_length = len[15:0];
    r.row_end = re;
    r.image_end = ie;
    return r;
  endfunction

  function automatic logic close_row(inout decoder_state_t s);
    s.row_idx = s.row_idx + 16'd1;
    s.col = '0;
    s.phase = EXPECT_WHITE;
    s.left = '0;
    s.nib = NIB_ALIGNED;
    if (s.row_idx >= s.height) s.done = 1'b1;
    return s.done;
  endfunction

  function automatic run_t finish_row(inout decoder_state_t s);
    logic [16:0] len;
    logic ie;
    len = rest_of_row(s);
    ie = close_row(s);
    return make_run(len, 1'b1, ie);
  endfunction

  // runs caused by one byte; returns how many
  function automatic int decode_byte(inout decoder_state_t s, input logic [7:0] b,
                                     output run_t [1:0] rr);
    int n;
    logic shown;
    logic got_pixel;
    logic ie;
    logic [7:0] c, m, y;
    n = 0;
    rr = '0;
    shown = 1'b0;
    got_pixel = 1'b0;
    c = '0;
    m = '0;
    y = '0;
    if (s.done) return 0;
    if (s.phase != IN_DATA && {8'd0, b} == s.width) begin
      rr[0] = finish_row(s);
      n = 1;
    end else if (s.phase == EXPECT_WHITE) begin
      if ({9'd0, b} >= rest_of_row(s)) begin
        rr[0] = finish_row(s);
        n = 1;
      end else begin
        if (b != 8'd0) begin
          rr[0] = make_run({9'd0, b}, 1'b0, 1'b0);
          n = 1;
        end
        s.col = s.col + {9'd0, b};
        s.phase = EXPECT_COUNT;
      end
    end else if (s.phase == EXPECT_COUNT) begin
      s.left = b;
      s.nib = NIB_ALIGNED;
      if (b == 8'd0) begin
        rr[0] = finish_row(s);
        n = 1;
      end else begin
        s.phase = IN_DATA;
      end
    end else begin
      got_pixel = 1'b1;
      case (s.nib)
        NIB_HELD: begin
          c = s.held & CHAN_MASK;
          m = {s.held[3:0], 4'h0};
          y = b & CHAN_MASK;
          s.held = b;
          s.nib = NIB_SPLIT;
        end
        NIB_SPLIT: begin
          c = {s.held[3:0], 4'h0};
          m = b & CHAN_MASK;
          y = {b[3:0], 4'h0};
          s.nib = NIB_ALIGNED;
        end
        default: begin
          s.held = b;
          s.nib = NIB_HELD;
          got_pixel = 1'b0;
        end
      endcase
      if (got_pixel) begin
        s.left = s.left - 8'd1;
        if (s.col < {1'b0, s.width}) begin
          rr[0] = make_run(17'd1, 1'b0, 1'b0);
          rr[0].cyan = c;
          rr[0].magenta = m;
          rr[0].yellow = y;
          n = 1;
          s.col = s.col + 17'd1;
          shown = 1'b1;
        end
        if (s.left == 8'd0) begin
          if (shown && s.col >= {1'b0, s.width}) begin
            ie = close_row(s);
            rr[0].row_end = 1'b1;
            rr[0].image_end = ie;
          end else begin
            rr[n] = finish_row(s);
            n = n + 1;
          end
        end
      end
    end
    if (n > 0) rr[n-1].last = 1'b1;
    return n;
  endfunction

  // mostly well-formed rows with random content, some noise
  function automatic logic [7:0] pick_byte(decoder_state_t s);
    logic [16:0] rem;
    int hi;
    int sel;
    rem = rest_of_row(s);
    sel = $urandom_range(0, 9);
    hi = (rem > 17'd255) ? 255 : int'(rem);
    if (s.phase == EXPECT_WHITE) begin
      if (sel == 0 && s.width <= 16'd255) return s.width[7:0];
      if (sel == 1) return 8'($urandom_range(hi, 255));
      if (sel == 2) return 8'($urandom);
      if (sel == 3 || hi == 0) return 8'd0;
      return 8'($urandom_range(0, hi - 1));
    end
    if (s.phase == EXPECT_COUNT) begin
      if (sel == 0) return 8'd0;
      if (sel == 1) return 8'($urandom);
      if (sel == 2) return 8'($urandom_range(hi, (hi + 3 > 255) ? 255 : hi + 3));
      return 8'($urandom_range(1, (hi > 40) ? 40 : ((hi < 1) ? 1 : hi)));
    end
    return 8'($urandom);
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    run_t [1:0] scratch_runs;
    int n;
    if (!gen_st.done) items_queued++;
    n = decode_byte(gen_st, b, scratch_runs);
    pending_bytes.push_back(b);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_IMAGE_WIDTH) begin
      dec_st.width = val;
      gen_st.width = val;
    end else begin
      dec_st.height = val;
      gen_st.height = val;
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_bytes.size() != 0 || expected_runs.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : take_byte
    run_t [1:0] made;
    int n;
    byte_taken = !rst && byte_ch.valid && byte_ch.ready;
    if (byte_taken) begin
      n = decode_byte(dec_st, byte_ch.data_byte, made);
      for (int i = 0; i < n; i++) expected_runs.push_back(made[i]);
      void'(pending_bytes.pop_front());
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else if (!byte_ch.valid || byte_taken) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 60);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        gap_left--;
        byte_ch.valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= pending_bytes[0];
        burst_left--;
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      run_ch.ready <= 1'b0;
    end else if (holds_granted != holds_asked) begin
      holds_granted++;
      hold_left = 300;
      run_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 60);
      end
      mode_left--;
      case (stall_mode)
        0: run_ch.ready <= 1'b1;
        1: run_ch.ready <= 1'($urandom_range(0, 1));
        default: run_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_runs
    run_t want;
    if (!rst && run_ch.valid && run_ch.ready) begin
      if (expected_runs.size() == 0) begin
        $error("unexpected run: length %0d", run_ch.run_length);
        mismatches++;
      end else begin
        want = expected_runs.pop_front();
        check_field("run_length", want.run_length, run_ch.run_length);
        check_field("cyan", want.cyan, run_ch.cyan);
        check_field("magenta", want.magenta, run_ch.magenta);
        check_field("yellow", want.yellow, run_ch.yellow);
        check_field("row_end", want.row_end, run_ch.row_end);
        check_field("image_end", want.image_end, run_ch.image_end);
        check_field("last", want.last, run_ch.last);
      end
    end
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int round;
    logic [15:0] w;
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    run_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_IMAGE_WIDTH;
    cfg_ch.data = '0;
    dec_st = reset_state();
    gen_st = reset_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(REG_IMAGE_HEIGHT, 16'hffff);
    write_reg(REG_IMAGE_WIDTH, 16'd6);
    foreach (opening_bytes[i]) queue_byte(opening_bytes[i]);
    settle();

    round = 0;
    while (items_queued < 820) begin
      if (round == 1) w = 16'd1;
      else if (round == 2) w = 16'hffff;
      else begin
        case ($urandom_range(0, 9))
          0: w = 16'd1;
          1: w = 16'($urandom_range(100, 255));
          2: w = 16'($urandom_range(256, 3000));
          default: w = 16'($urandom_range(2, 24));
        endcase
      end
      write_reg(REG_IMAGE_WIDTH, w);
      if (round % 7 == 3) write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(40000, 65534)));
      // long output stall while input keeps coming
      if (round == 4) holds_asked++;
      repeat ((round == 4) ? 150 : $urandom_range(15, 60)) queue_byte(pick_byte(gen_st));
      settle();
      round++;
    end

    // height below rows done: image ends at the next row end, then ignored bytes
    write_reg(REG_IMAGE_WIDTH, 16'd5);
    write_reg(REG_IMAGE_HEIGHT, 16'd1);
    while (!gen_st.done) queue_byte(pick_byte(gen_st));
    repeat (8) queue_byte(8'($urandom));
    settle();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
